// ===== rtl/apsp_pkg.sv =====
// Shared types, constants and cost arithmetic for the all-pairs shortest path block.
package apsp_pkg;

   localparam int MAX_POINTS = 8;
   localparam int NODE_W     = 3;
   localparam int CMD_W      = 2;
   localparam int EDGE_W     = 16;
   localparam int COST_W     = 24;
   localparam int NUM_W      = 4;

   localparam logic [NUM_W-1:0] NUM_POINTS_RST = 4'd8;

   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOLVE    = 2'd2;

   localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
   localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [NODE_W-1:0]        src_node;
      logic [NODE_W-1:0]        dst_node;
      logic signed [EDGE_W-1:0] edge_cost;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0]        row;
      logic [NODE_W-1:0]        col;
      logic signed [COST_W-1:0] distance;
      logic                     reachable;
      logic                     negative_cycle;
      logic                     last;
   } rsp_word_type;

   typedef struct packed {
      logic                     valid;
      logic signed [COST_W-1:0] cost;
   } cell_type;

   typedef struct packed {
      logic     we;
      logic     clear;
      cell_type wdata;
   } store_ctl_type;

   function automatic logic signed [COST_W-1:0] sat_add(
      input logic signed [COST_W-1:0] a,
      input logic signed [COST_W-1:0] b
   );
      logic [COST_W:0] s;
      s = {a[COST_W-1], a} + {b[COST_W-1], b};
      if (s[COST_W] != s[COST_W-1]) begin
         return s[COST_W] ? COST_MIN : COST_MAX;
      end
      return s[COST_W-1:0];
   endfunction

endpackage

// ===== rtl/apsp_store.sv =====
// Cost matrix memory: one write port, two registered read ports, written bits and bypass.
module apsp_store import apsp_pkg::*; #(
   parameter int MaxPoints = MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [2*$clog2(MaxPoints)-1:0]      rd_a_addr,
   input  logic [2*$clog2(MaxPoints)-1:0]      rd_b_addr,
   input  logic [2*$clog2(MaxPoints)-1:0]      wr_addr,
   input  store_ctl_type                       ctl,
   output cell_type                            rd_a,
   output cell_type                            rd_b
);

   localparam int NodeW = $clog2(MaxPoints);
   localparam int AddrW = 2 * NodeW;
   localparam int Depth = 1 << AddrW;

   cell_type         mem_ff [Depth];
   logic [Depth-1:0] written_ff;

   cell_type a_q_ff, b_q_ff, byp_data_ff;
   logic     a_wr_ff, b_wr_ff, a_diag_ff, b_diag_ff, a_byp_ff, b_byp_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[wr_addr] <= ctl.wdata;
      end
      a_q_ff      <= mem_ff[rd_a_addr];
      b_q_ff      <= mem_ff[rd_b_addr];
      a_wr_ff     <= written_ff[rd_a_addr];
      b_wr_ff     <= written_ff[rd_b_addr];
      a_diag_ff   <= rd_a_addr[AddrW-1:NodeW] == rd_a_addr[NodeW-1:0];
      b_diag_ff   <= rd_b_addr[AddrW-1:NodeW] == rd_b_addr[NodeW-1:0];
      byp_data_ff <= ctl.wdata;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         written_ff <= '0;
         a_byp_ff   <= 1'b0;
         b_byp_ff   <= 1'b0;
      end else begin
         if (ctl.we) begin
            written_ff[wr_addr] <= 1'b1;
         end
         a_byp_ff <= ctl.we && (wr_addr == rd_a_addr);
         b_byp_ff <= ctl.we && (wr_addr == rd_b_addr);
      end
   end

   always_comb begin
      if (a_byp_ff) begin
         rd_a = byp_data_ff;
      end else if (a_wr_ff) begin
         rd_a = a_q_ff;
      end else begin
         rd_a = '{valid: a_diag_ff, cost: '0};
      end
      if (b_byp_ff) begin
         rd_b = byp_data_ff;
      end else if (b_wr_ff) begin
         rd_b = b_q_ff;
      end else begin
         rd_b = '{valid: b_diag_ff, cost: '0};
      end
   end

endmodule

// ===== rtl/apsp_ctrl.sv =====
// Sequencer: edge updates, relaxation passes, diagonal check and matrix readout.
module apsp_ctrl import apsp_pkg::*; #(
   parameter int MaxPoints = MAX_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MaxPoints)-1:0]    last_idx,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  req_word_type                    req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rsp_word_type                    rsp_word,
   output logic [2*$clog2(MaxPoints)-1:0]  rd_a_addr,
   output logic [2*$clog2(MaxPoints)-1:0]  rd_b_addr,
   output logic [2*$clog2(MaxPoints)-1:0]  wr_addr,
   output store_ctl_type                   ctl,
   input  cell_type                        rd_a,
   input  cell_type                        rd_b
);

   localparam int NodeW     = $clog2(MaxPoints);
   localparam int AddrW     = 2 * NodeW;
   localparam int PassLimit = MaxPoints * MaxPoints + 1;
   localparam int PassW     = $clog2(PassLimit);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_STEP, ST_DIAG, ST_DIAG_WAIT, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      DK_NONE, DK_EDGE, DK_INIT, DK_STEP, DK_DIAG, DK_OUT
   } data_kind_type;

   state_type     state_ff, state_in;
   data_kind_type dk_ff, dk_in;
   logic [NodeW-1:0] s_ff, s_in, d_ff, d_in, k_ff, k_in;
   logic [PassW-1:0] pass_ff, pass_in;
   logic changed_ff, changed_in, neg_ff, neg_in;
   logic dlast_ff, dlast_in, dfa_ff, dfa_in, dfb_ff, dfb_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AddrW-1:0] daddr_ff, daddr_in;
   logic signed [COST_W-1:0] dcost_ff, dcost_in;
   cell_type     acc_ff, acc_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   cell_type op_a, op_b, acc_new;
   logic signed [COST_W-1:0] cand;
   logic diag_hit, neg_now, last_pair;
   logic [NODE_W-1:0] last_node;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign req_ready = state_ff == ST_IDLE;
   assign last_node = NODE_W'(last_idx);
   assign last_pair = (s_ff == last_idx) && (d_ff == last_idx);

   always_comb begin
      state_in    = state_ff;
      dk_in       = DK_NONE;
      s_in        = s_ff;
      d_in        = d_ff;
      k_in        = k_ff;
      pass_in     = pass_ff;
      changed_in  = changed_ff;
      neg_in      = neg_ff;
      dlast_in    = 1'b0;
      dfa_in      = 1'b0;
      dfb_in      = 1'b0;
      daddr_in    = daddr_ff;
      dcost_in    = dcost_ff;
      acc_in      = acc_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_a_addr   = '0;
      rd_b_addr   = '0;
      wr_addr     = daddr_ff;
      ctl         = '{we: 1'b0, clear: 1'b0, wdata: '0};

      op_a     = dfa_ff ? acc_ff : rd_a;
      op_b     = dfb_ff ? acc_ff : rd_b;
      cand     = sat_add(op_a.cost, op_b.cost);
      acc_new  = acc_ff;
      if (op_a.valid && op_b.valid && (!acc_ff.valid || acc_ff.cost > cand)) begin
         acc_new = '{valid: 1'b1, cost: cand};
      end
      diag_hit = !rd_a.valid || (rd_a.cost != '0);
      neg_now  = neg_ff || diag_hit;

      case (dk_ff)
         DK_EDGE: begin
            if (!rd_a.valid || rd_a.cost > dcost_ff) begin
               ctl.we    = 1'b1;
               ctl.wdata = '{valid: 1'b1, cost: dcost_ff};
            end
         end
         DK_INIT: acc_in = rd_a;
         DK_STEP: begin
            acc_in = acc_new;
            if (acc_new != acc_ff) begin
               changed_in = 1'b1;
            end
            if (dlast_ff) begin
               ctl.we    = 1'b1;
               ctl.wdata = acc_new;
            end
         end
         DK_DIAG: begin
            if (diag_hit) begin
               neg_in = 1'b1;
            end
         end
         DK_OUT: begin
            rsp_valid_in                = 1'b1;
            rsp_word_in.row             = NODE_W'(daddr_ff[AddrW-1:NodeW]);
            rsp_word_in.col             = NODE_W'(daddr_ff[NodeW-1:0]);
            rsp_word_in.distance        = rd_a.valid ? rd_a.cost : '0;
            rsp_word_in.reachable       = rd_a.valid;
            rsp_word_in.negative_cycle  = neg_ff;
            rsp_word_in.last            = dlast_ff;
         end
         default: ;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_word.cmd)
                  CMD_CLEAR: ctl.clear = 1'b1;
                  CMD_ADD_EDGE: begin
                     if (req_word.src_node <= last_node && req_word.dst_node <= last_node) begin
                        rd_a_addr = {req_word.src_node[NodeW-1:0],
                                     req_word.dst_node[NodeW-1:0]};
                        daddr_in  = rd_a_addr;
                        dcost_in  = COST_W'(req_word.edge_cost);
                        dk_in     = DK_EDGE;
                     end
                  end
                  CMD_SOLVE: begin
                     s_in       = '0;
                     d_in       = '0;
                     pass_in    = '0;
                     changed_in = 1'b0;
                     state_in   = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            rd_a_addr = {s_ff, d_ff};
            dk_in     = DK_INIT;
            k_in      = '0;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            rd_a_addr = {s_ff, k_ff};
            rd_b_addr = {k_ff, d_ff};
            dk_in     = DK_STEP;
            dfa_in    = k_ff == d_ff;
            dfb_in    = k_ff == s_ff;
            daddr_in  = {s_ff, d_ff};
            dlast_in  = k_ff == last_idx;
            if (k_ff == last_idx) begin
               if (last_pair) begin
                  k_in     = '0;
                  neg_in   = 1'b0;
                  state_in = ST_DIAG;
               end else begin
                  if (d_ff == last_idx) begin
                     s_in = s_ff + 1'b1;
                     d_in = '0;
                  end else begin
                     d_in = d_ff + 1'b1;
                  end
                  state_in = ST_INIT;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DIAG: begin
            rd_a_addr = {k_ff, k_ff};
            dk_in     = DK_DIAG;
            if (k_ff == last_idx) begin
               state_in = ST_DIAG_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DIAG_WAIT: begin
            s_in = '0;
            d_in = '0;
            if (neg_now || !changed_ff || pass_ff == PassW'(PassLimit - 1)) begin
               state_in = ST_OUT;
            end else begin
               pass_in    = pass_ff + 1'b1;
               changed_in = 1'b0;
               state_in   = ST_INIT;
            end
         end
         ST_OUT: begin
            if (dk_ff != DK_OUT && (!rsp_valid_ff || rsp_ready)) begin
               rd_a_addr = {s_ff, d_ff};
               daddr_in  = rd_a_addr;
               dk_in     = DK_OUT;
               dlast_in  = last_pair;
               if (last_pair) begin
                  state_in = ST_IDLE;
               end else if (d_ff == last_idx) begin
                  s_in = s_ff + 1'b1;
                  d_in = '0;
               end else begin
                  d_in = d_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ctl.clear) begin
         ctl.we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dk_ff        <= DK_NONE;
         rsp_valid_ff <= 1'b0;
         changed_ff   <= 1'b0;
         neg_ff       <= 1'b0;
         pass_ff      <= '0;
         s_ff         <= '0;
         d_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         dk_ff        <= dk_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff   <= changed_in;
         neg_ff       <= neg_in;
         pass_ff      <= pass_in;
         s_ff         <= s_in;
         d_ff         <= d_in;
         k_ff         <= k_in;
      end
      dlast_ff    <= dlast_in;
      dfa_ff      <= dfa_in;
      dfb_ff      <= dfb_in;
      daddr_ff    <= daddr_in;
      dcost_ff    <= dcost_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== rtl/all_pairs_shortest_path.sv =====
// Top level of the all-pairs shortest path block: node count register, store and sequencer.
//
//  port group  dir  handshake          word
//  req_*       in   valid / ready      req_word_type  (clear, add edge, solve)
//  rsp_*       out  valid / ready      rsp_word_type  (one word per matrix entry)
//  csr_*       in   write enable only  num_points, 4 bits
//
//  Clear and add edge may follow back to back; readout fetches one word at a time.
//  Solve, N active nodes: each pass relaxes every pair through the one shared
//  relaxation unit and the two memory read ports; passes repeat until nothing
//  changes, a diagonal goes nonzero or the pass limit is reached.
//  Reset restores the matrix at once through per-entry written bits; no sweep.
//  A stalled rsp_ready holds the readout; req_ready is low from solve to last read.
module all_pairs_shortest_path import apsp_pkg::*; #(
   parameter int MaxPoints = MAX_POINTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   input  logic              csr_wr_en,
   input  logic [NUM_W-1:0]  csr_wr_data
);

   localparam int NodeW = $clog2(MaxPoints);
   localparam int AddrW = 2 * NodeW;

   logic [NUM_W-1:0] num_points_ff;
   logic [NodeW-1:0] last_idx;
   logic [AddrW-1:0] rd_a_addr, rd_b_addr, wr_addr;
   store_ctl_type    ctl;
   cell_type         rd_a, rd_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RST;
      end else if (csr_wr_en) begin
         num_points_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (num_points_ff == '0) begin
         last_idx = '0;
      end else if (num_points_ff > NUM_W'(MaxPoints)) begin
         last_idx = NodeW'(MaxPoints - 1);
      end else begin
         last_idx = NodeW'(num_points_ff - 1'b1);
      end
   end

   apsp_store #(.MaxPoints(MaxPoints)) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr_addr   (wr_addr),
      .ctl       (ctl),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   apsp_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .last_idx  (last_idx),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr_addr   (wr_addr),
      .ctl       (ctl),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

endmodule

// ===== rtl/apsp_checker.sv =====
// Port-level assertions for the all-pairs shortest path block, bound to the top level.
module apsp_checker import apsp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input req_word_type      req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsp_word_type      rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word dropped or changed while stalled");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.cmd == CMD_SOLVE |=> !req_ready)
      else $error("request taken during solve");

   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |-> rsp_word.row == rsp_word.col)
      else $error("last word is not a diagonal entry");

   a_diag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.row == rsp_word.col && !rsp_word.negative_cycle
      |-> rsp_word.reachable && rsp_word.distance == '0)
      else $error("diagonal nonzero without negative cycle flag");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);

// ===== sim/tb_all_pairs_shortest_path.sv =====
// Self-checking testbench for the all-pairs shortest path block: directed and random traffic.
`timescale 1ns / 1ps

import apsp_pkg::*;

class distance_board;
   cell_type         grid [MAX_POINTS][MAX_POINTS];
   logic [NUM_W-1:0] points_reg;
   rsp_word_type     pending_entries [$];
   int               mismatches;

   function new();
      clear_grid();
      points_reg = NUM_POINTS_RST;
      mismatches = 0;
   endfunction

   function void clear_grid();
      for (int i = 0; i < MAX_POINTS; i++) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            grid[i][j].valid = (i == j);
            grid[i][j].cost  = '0;
         end
      end
   endfunction

   function void set_points(logic [NUM_W-1:0] v);
      points_reg = v;
   endfunction

   function int live_points();
      if (int'(points_reg) == 0) return 1;
      if (int'(points_reg) > MAX_POINTS) return MAX_POINTS;
      return int'(points_reg);
   endfunction

   function int clamp_sum(int a, int b);
      int s;
      s = a + b;
      if (s > int'(COST_MAX)) return int'(COST_MAX);
      if (s < int'(COST_MIN)) return int'(COST_MIN);
      return s;
   endfunction

   function bit relax_once(int n);
      bit moved;
      int cand;
      int held;
      moved = 1'b0;
      for (int s = 0; s < n; s++) begin
         for (int d = 0; d < n; d++) begin
            for (int k = 0; k < n; k++) begin
               if (grid[s][k].valid && grid[k][d].valid) begin
                  cand = clamp_sum($signed(grid[s][k].cost), $signed(grid[k][d].cost));
                  held = $signed(grid[s][d].cost);
                  if (!grid[s][d].valid || held > cand) begin
                     grid[s][d].valid = 1'b1;
                     grid[s][d].cost  = cand[COST_W-1:0];
                     moved = 1'b1;
                  end
               end
            end
         end
      end
      return moved;
   endfunction

   function bit diag_broken(int n);
      for (int i = 0; i < n; i++) begin
         if (!grid[i][i].valid || grid[i][i].cost != '0) return 1'b1;
      end
      return 1'b0;
   endfunction

   function void solve_and_list();
      int           n;
      bit           neg;
      bit           moved;
      rsp_word_type e;
      n   = live_points();
      neg = 1'b0;
      for (int p = 0; p < MAX_POINTS * MAX_POINTS + 1; p++) begin
         moved = relax_once(n);
         neg   = diag_broken(n);
         if (neg || !moved) break;
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            e.row            = i[NODE_W-1:0];
            e.col            = j[NODE_W-1:0];
            e.distance       = grid[i][j].valid ? grid[i][j].cost : '0;
            e.reachable      = grid[i][j].valid;
            e.negative_cycle = neg;
            e.last           = (i == n - 1) && (j == n - 1);
            pending_entries.push_back(e);
         end
      end
   endfunction

   // returns 1 for clear, solve and every add edge inside the live nodes
   function bit note_command(req_word_type w);
      int n;
      int ec;
      n = live_points();
      case (w.cmd)
         CMD_CLEAR: begin
            clear_grid();
            return 1'b1;
         end
         CMD_ADD_EDGE: begin
            if (int'(w.src_node) >= n || int'(w.dst_node) >= n) return 1'b0;
            ec = $signed(w.edge_cost);
            if (!grid[w.src_node][w.dst_node].valid ||
                $signed(grid[w.src_node][w.dst_node].cost) > ec) begin
               grid[w.src_node][w.dst_node].valid = 1'b1;
               grid[w.src_node][w.dst_node].cost  = ec[COST_W-1:0];
            end
            return 1'b1;
         end
         CMD_SOLVE: begin
            solve_and_list();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function void check_entry(rsp_word_type got);
      rsp_word_type want;
      if (pending_entries.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: row %0d col %0d distance %0d reach %0b neg %0b last %0b",
                     got.row, got.col, $signed(got.distance), got.reachable,
                     got.negative_cycle, got.last);
         return;
      end
      want = pending_entries.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.distance !== want.distance ||
          got.reachable !== want.reachable || got.negative_cycle !== want.negative_cycle ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected row %0d col %0d distance %0d reach %0b neg %0b last %0b",
                     want.row, want.col, $signed(want.distance), want.reachable,
                     want.negative_cycle, want.last);
            $display("          actual   row %0d col %0d distance %0d reach %0b neg %0b last %0b",
                     got.row, got.col, $signed(got.distance), got.reachable,
                     got.negative_cycle, got.last);
         end
      end
   endfunction

   function int pending_count();
      return pending_entries.size();
   endfunction
endclass

module tb_all_pairs_shortest_path;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_TARGET   = 380;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_word_type     req_word    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_wr_en   = 1'b0;
   logic [NUM_W-1:0] csr_wr_data = '0;

   distance_board board = new();

   bit steady          = 1'b0;
   bit hold_request    = 1'b0;
   int hold_left       = 0;
   int cycle_count     = 0;
   int effective_items = 0;

   all_pairs_shortest_path dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("all_pairs_shortest_path test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) board.check_entry(rsp_word);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && rsp_valid === 1'b1) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 25);
      end
   end

   function automatic req_word_type make_word(logic [CMD_W-1:0] c, int s, int d, int cost);
      req_word_type w;
      w.cmd       = c;
      w.src_node  = s[NODE_W-1:0];
      w.dst_node  = d[NODE_W-1:0];
      w.edge_cost = cost[EDGE_W-1:0];
      return w;
   endfunction

   function automatic int pick_cost(int style);
      case (style)
         0: return $urandom_range(100);
         1: return int'($urandom_range(220)) - 20;
         2: return $urandom_range(65535);
         default: begin
            case ($urandom_range(3))
               0: return -32768;
               1: return 32767;
               2: return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic int pick_node();
      if ($urandom_range(9) == 0) return $urandom_range(7);
      return $urandom_range(board.live_points() - 1);
   endfunction

   task automatic send_word(req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (board.note_command(w)) effective_items++;
      if (!steady && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // hold the sender until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_points(logic [NUM_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      board.set_points(v);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int               n_set;
      int               kind;
      int               style;
      int               phase;
      logic [CMD_W-1:0] noise_cmd;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      send_word(make_word(CMD_SPARE, 7, 7, -1));
      send_word(make_word(CMD_ADD_EDGE, 0, 1, 32767));
      send_word(make_word(CMD_ADD_EDGE, 1, 7, 32767));
      send_word(make_word(CMD_ADD_EDGE, 7, 0, 5));
      send_word(make_word(CMD_ADD_EDGE, 0, 1, 100));
      send_word(make_word(CMD_ADD_EDGE, 0, 1, 200));
      send_word(make_word(CMD_SOLVE, 7, 7, 0));
      send_word(make_word(CMD_ADD_EDGE, 2, 3, -32768));
      send_word(make_word(CMD_ADD_EDGE, 3, 2, 32767));
      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      settle();
      write_points(4'd3);
      send_word(make_word(CMD_ADD_EDGE, 5, 1, 7));
      send_word(make_word(CMD_ADD_EDGE, 2, 7, 7));
      send_word(make_word(CMD_ADD_EDGE, 2, 0, -7));
      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      settle();
      write_points(4'd0);
      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      send_word(make_word(CMD_CLEAR, 7, 7, -1));
      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      settle();
      write_points(4'd15);
      send_word(make_word(CMD_ADD_EDGE, 7, 7, -1));
      send_word(make_word(CMD_SOLVE, 0, 0, 0));
      send_word(make_word(CMD_CLEAR, 0, 0, 0));
      settle();
      write_points(4'd1);
      send_word(make_word(CMD_ADD_EDGE, 0, 0, 0));
      send_word(make_word(CMD_SOLVE, 0, 0, 0));

      phase = 0;
      while (effective_items < ITEM_TARGET) begin
         settle();
         case ($urandom_range(9))
            0: n_set = 0;
            1: n_set = 15;
            2: n_set = 8;
            default: n_set = $urandom_range(1, 7);
         endcase
         write_points(n_set[NUM_W-1:0]);
         steady = (phase == 2);
         if (phase == 4) hold_request = 1'b1;
         repeat ($urandom_range(2, 4)) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
               style = $urandom_range(3);
               if ($urandom_range(9) != 0)
                  send_word(make_word(CMD_CLEAR, pick_node(), pick_node(), pick_cost(2)));
               repeat ($urandom_range(1, 2 * board.live_points()))
                  send_word(make_word(CMD_ADD_EDGE, pick_node(), pick_node(), pick_cost(style)));
               send_word(make_word(CMD_SOLVE, pick_node(), pick_node(), pick_cost(2)));
            end else if (kind < 80) begin
               // drive costs to the floor so that sums saturate
               send_word(make_word(CMD_CLEAR, 0, 0, 0));
               repeat (board.live_points() + 4)
                  send_word(make_word(CMD_ADD_EDGE, pick_node(), pick_node(), -32768));
               send_word(make_word(CMD_SOLVE, 0, 0, 0));
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  noise_cmd = CMD_W'($urandom_range(3));
                  send_word(make_word(noise_cmd, $urandom_range(7), $urandom_range(7),
                                      $urandom_range(65535)));
               end
            end
         end
         phase++;
      end
      steady = 1'b0;
      settle();
      repeat (40) @(posedge clock);

      if (board.mismatches == 0 && board.pending_count() == 0) begin
         $display("all_pairs_shortest_path test passed");
      end else begin
         $display("all_pairs_shortest_path test failed");
      end
      $finish;
   end
endmodule
